@@ hdl/hamming_sec_codec_assert.svh @@
// assertion macros for the hamming codec
`ifndef HAMMING_SEC_CODEC_ASSERT_SVH
`define HAMMING_SEC_CODEC_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hamming codec check failed");

// next-cycle implication
`define HSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hamming codec check failed");

`else

`define HSC_ASSERT_NOW(label, clk, rst, ante, cons)
`define HSC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/hsc_pkg.sv @@
`timescale 1ns / 1ps

package hsc_pkg;

   localparam int DATA_W          = 38;
   localparam int SYN_W           = 6;
   localparam int STATUS_W        = 2;
   localparam int MAX_POS         = 63;
   localparam int CMP_W           = $clog2(MAX_POS + 1) + 1;
   localparam int MSG_BITS_DEF    = 32;
   localparam int PARITY_BITS_DEF = 6;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_CLEAN     = 2'd0,
      ST_CORRECTED = 2'd1,
      ST_PARITY    = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   function automatic bit pos_is_pow2(input int p);
      return (p > 0) && ((p & (p - 1)) == 0);
   endfunction

   // 1-based code position of message bit m
   function automatic int msg_pos(input int m);
      int cnt;
      int res;
      cnt = 0;
      res = 0;
      for (int pos = 1; pos <= MAX_POS; pos++) begin
         if (!pos_is_pow2(pos)) begin
            if (cnt == m && res == 0) begin
               res = pos;
            end
            cnt++;
         end
      end
      return res;
   endfunction

   // message bit index held at code position p
   function automatic int pos_slot(input int p);
      int cnt;
      cnt = 0;
      for (int pos = 1; pos < p; pos++) begin
         if (!pos_is_pow2(pos)) begin
            cnt++;
         end
      end
      return cnt;
   endfunction

   // positions whose index has bit r set, bit i is position i+1
   function automatic logic [MAX_POS-1:0] syn_mask(input int r);
      logic [MAX_POS-1:0] m;
      m = '0;
      for (int pos = 1; pos <= MAX_POS; pos++) begin
         m[pos-1] = ((pos >> r) & 1) != 0;
      end
      return m;
   endfunction

endpackage

@@ hdl/hamming_sec_codec.sv @@
`timescale 1ns / 1ps
// Shortened single-error-correcting Hamming codec. A request with op clear
// encodes the message in the low bits of data_in into a codeword with parity
// at the power-of-two positions; with op set it checks a codeword, corrects a
// single flipped message bit and returns the message with its syndrome and
// status. The datapath is a three-stage pipeline (input register, syndrome
// XOR trees, correction and output register): one request is taken every
// cycle while the response channel is not stalled, and each request passes
// the input, syndrome and output registers in turn before its response is
// valid. Each stage has its own valid bit and holds under back-pressure, so
// bubbles are squeezed out.
`include "hamming_sec_codec_assert.svh"

module hamming_sec_codec
   import hsc_pkg::*;
#(
   parameter int MSG_BITS    = MSG_BITS_DEF,
   parameter int PARITY_BITS = PARITY_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [DATA_W-1:0]   req_data_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DATA_W-1:0]   rsp_data_out,
   output logic [SYN_W-1:0]    rsp_syndrome,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int CODE_BITS = MSG_BITS + PARITY_BITS;
   localparam int MSG_OUT   = (MSG_BITS < DATA_W) ? MSG_BITS : DATA_W;

   // stage readiness
   logic s1_ready;
   logic s2_ready;
   logic s3_ready;

   // stage 1: input register
   logic              s1_valid_ff;
   logic              s1_op_ff;
   logic [DATA_W-1:0] s1_data_ff;

   // stage 2: spread word and syndrome
   logic                   s2_valid_ff;
   logic                   s2_op_ff;
   logic [CODE_BITS-1:0]   s2_spread_ff;
   logic [PARITY_BITS-1:0] s2_syn_ff;
   logic [CODE_BITS-1:0]   enc_spread;
   logic [CODE_BITS-1:0]   dec_spread;
   logic [CODE_BITS-1:0]   s2_spread_in;
   logic [PARITY_BITS-1:0] s2_syn_in;

   // stage 3: output register
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_data_out_ff;
   logic [SYN_W-1:0]    rsp_syndrome_ff;
   status_type          rsp_status_ff;
   logic [DATA_W-1:0]   rsp_data_out_in;
   logic [SYN_W-1:0]    rsp_syndrome_in;
   status_type          rsp_status_in;
   logic [MSG_OUT-1:0]  dec_msg;
   logic [MSG_OUT-1:0]  dec_flip;
   logic [DATA_W-1:0]   enc_code;
   logic [CMP_W-1:0]    syn_ext;
   logic                syn_pow2;

   assign s3_ready  = !rsp_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   // stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_op_ff   <= req_op;
         s1_data_ff <= req_data_in;
      end
   end

   // place message bits (encode) or take code bits as they are (decode)
   for (genvar pos = 1; pos <= CODE_BITS; pos++) begin : g_spread
      localparam int SLOT = pos_slot(pos);
      if (!pos_is_pow2(pos) && SLOT < MSG_OUT) begin : g_msg
         assign enc_spread[pos-1] = s1_data_ff[SLOT];
      end else begin : g_par
         assign enc_spread[pos-1] = 1'b0;
      end
      if (pos <= DATA_W) begin : g_in
         assign dec_spread[pos-1] = s1_data_ff[pos-1];
      end else begin : g_out
         assign dec_spread[pos-1] = 1'b0;
      end
   end

   assign s2_spread_in = (s1_op_ff == OP_DECODE) ? dec_spread : enc_spread;

   for (genvar r = 0; r < PARITY_BITS; r++) begin : g_syn
      localparam logic [MAX_POS-1:0] MASK = syn_mask(r);
      assign s2_syn_in[r] = ^(s2_spread_in & MASK[CODE_BITS-1:0]);
   end

   // stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_op_ff     <= s1_op_ff;
         s2_spread_ff <= s2_spread_in;
         s2_syn_ff    <= s2_syn_in;
      end
   end

   // message gather and single-bit correction
   for (genvar m = 0; m < MSG_OUT; m++) begin : g_msg
      localparam int P = msg_pos(m);
      if (P <= CODE_BITS) begin : g_in
         assign dec_msg[m]  = s2_spread_ff[P-1];
         assign dec_flip[m] = (syn_ext == CMP_W'(P));
      end else begin : g_out
         assign dec_msg[m]  = 1'b0;
         assign dec_flip[m] = 1'b0;
      end
   end

   // codeword: message positions plus parity at powers of two
   for (genvar i = 0; i < DATA_W; i++) begin : g_code
      if (i >= CODE_BITS) begin : g_none
         assign enc_code[i] = 1'b0;
      end else if (pos_is_pow2(i + 1) && $clog2(i + 1) < PARITY_BITS) begin : g_par
         assign enc_code[i] = s2_syn_ff[$clog2(i + 1)];
      end else begin : g_dat
         assign enc_code[i] = s2_spread_ff[i];
      end
   end

   assign syn_ext  = CMP_W'(s2_syn_ff);
   assign syn_pow2 = (s2_syn_ff != '0) && ((s2_syn_ff & (s2_syn_ff - 1'b1)) == '0);

   always_comb begin
      rsp_data_out_in = enc_code;
      rsp_syndrome_in = '0;
      rsp_status_in   = ST_CLEAN;
      if (s2_op_ff == OP_DECODE) begin
         rsp_data_out_in = DATA_W'(dec_msg ^ dec_flip);
         rsp_syndrome_in = SYN_W'(s2_syn_ff);
         if (s2_syn_ff == '0) begin
            rsp_status_in = ST_CLEAN;
         end else if (syn_ext > CMP_W'(CODE_BITS)) begin
            rsp_status_in   = ST_RANGE;
            rsp_data_out_in = DATA_W'(dec_msg);
         end else if (syn_pow2) begin
            rsp_status_in = ST_PARITY;
         end else begin
            rsp_status_in = ST_CORRECTED;
         end
      end
   end

   // stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         rsp_data_out_ff <= rsp_data_out_in;
         rsp_syndrome_ff <= rsp_syndrome_in;
         rsp_status_ff   <= rsp_status_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_out_ff;
   assign rsp_syndrome = rsp_syndrome_ff;
   assign rsp_status   = rsp_status_ff;

   // checks
   `HSC_ASSERT_NOW(a_corr_syn, clock, reset, rsp_valid && rsp_status == ST_CORRECTED, rsp_syndrome != '0 && !$onehot(rsp_syndrome))
   `HSC_ASSERT_NOW(a_par_syn, clock, reset, rsp_valid && rsp_status == ST_PARITY, $onehot(rsp_syndrome))
   `HSC_ASSERT_NEXT(a_enc_clean, clock, reset, s2_valid_ff && s3_ready && s2_op_ff == OP_ENCODE, rsp_syndrome == '0 && rsp_status == ST_CLEAN)
   `HSC_ASSERT_NEXT(a_no_loss, clock, reset, s2_valid_ff && !s3_ready, s2_valid_ff && $stable(s2_syn_ff))

endmodule

@@ sim/tb_hamming_sec_codec.sv @@
`timescale 1ns / 1ps

module tb_hamming_sec_codec;
   import hsc_pkg::*;

   localparam int MSG_BITS  = MSG_BITS_DEF;
   localparam int PAR_BITS  = PARITY_BITS_DEF;
   localparam int CODE_BITS = MSG_BITS + PAR_BITS;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [SYN_W-1:0]  syndrome;
      status_type        status;
   } codec_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_op = OP_ENCODE;
   logic [DATA_W-1:0]   req_data_in = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DATA_W-1:0]   rsp_data_out;
   logic [SYN_W-1:0]    rsp_syndrome;
   logic [STATUS_W-1:0] rsp_status;

   codec_result_type pending_results[$];
   int               mismatch_count = 0;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;

   hamming_sec_codec u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_data_in  (req_data_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data_out (rsp_data_out),
      .rsp_syndrome (rsp_syndrome),
      .rsp_status   (rsp_status)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic power_of_two(input int p);
      return (p != 0) && ((p & (p - 1)) == 0);
   endfunction

   function automatic logic [DATA_W-1:0] hamming_codeword(input logic [DATA_W-1:0] msg);
      logic [DATA_W-1:0] code;
      logic [SYN_W-1:0]  par;
      int                m;
      code = '0;
      par  = '0;
      m    = 0;
      for (int pos = 1; pos <= CODE_BITS; pos++) begin
         if (!power_of_two(pos)) begin
            if (m < MSG_BITS && msg[m]) begin
               code[pos-1] = 1'b1;
               par ^= SYN_W'(pos);
            end
            m++;
         end
      end
      for (int r = 0; r < PAR_BITS; r++) begin
         if (par[r] && (1 << r) <= CODE_BITS) begin
            code[(1 << r) - 1] = 1'b1;
         end
      end
      return code;
   endfunction

   function automatic codec_result_type predict_codec(input logic op,
                                                      input logic [DATA_W-1:0] din);
      codec_result_type  res;
      logic [SYN_W-1:0]  syn;
      logic [DATA_W-1:0] msg;
      int                m;
      int                slot;
      res = '0;
      if (op == OP_ENCODE) begin
         res.data     = hamming_codeword(din);
         res.syndrome = '0;
         res.status   = ST_CLEAN;
         return res;
      end
      syn = '0;
      msg = '0;
      m   = 0;
      for (int pos = 1; pos <= CODE_BITS; pos++) begin
         if (din[pos-1]) begin
            syn ^= SYN_W'(pos);
         end
         if (!power_of_two(pos)) begin
            if (m < MSG_BITS && din[pos-1]) begin
               msg[m] = 1'b1;
            end
            m++;
         end
      end
      if (syn == '0) begin
         res.status = ST_CLEAN;
      end else if (int'(syn) > CODE_BITS) begin
         res.status = ST_RANGE;
      end else if (power_of_two(int'(syn))) begin
         res.status = ST_PARITY;
      end else begin
         slot = 0;
         for (int pos = 1; pos < int'(syn); pos++) begin
            if (!power_of_two(pos)) begin
               slot++;
            end
         end
         if (slot < MSG_BITS) begin
            msg[slot] = ~msg[slot];
         end
         res.status = ST_CORRECTED;
      end
      res.data     = msg;
      res.syndrome = syn;
      return res;
   endfunction

   function automatic logic [DATA_W-1:0] random_word();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] flip_at(input logic [DATA_W-1:0] w, input int pos);
      return w ^ (DATA_W'(1) << (pos - 1));
   endfunction

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      codec_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response data %h syndrome %0d status %0d",
                     $time, rsp_data_out, rsp_syndrome, rsp_status);
            mismatch_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_data_out !== exp_res.data) begin
               $display("%0t: data_out expected %h actual %h",
                        $time, exp_res.data, rsp_data_out);
               mismatch_count++;
            end
            if (rsp_syndrome !== exp_res.syndrome) begin
               $display("%0t: syndrome expected %0d actual %0d",
                        $time, exp_res.syndrome, rsp_syndrome);
               mismatch_count++;
            end
            if (rsp_status !== exp_res.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, exp_res.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_request(input logic op, input logic [DATA_W-1:0] data);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_data_in <= data;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_codec(op, data));
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_encode_extremes();
      send_request(OP_ENCODE, '0);
      send_request(OP_ENCODE, '1);
      send_request(OP_ENCODE, 38'h00_ffff_ffff);
      send_request(OP_ENCODE, 38'h3f_0000_0000);
      send_request(OP_ENCODE, 38'h00_0000_0001);
      send_request(OP_ENCODE, 38'h00_8000_0000);
      send_request(OP_ENCODE, 38'h15_5555_5555);
      wait_for_drain();
   endtask

   task automatic test_decode_cases();
      logic [DATA_W-1:0] cw;
      cw = hamming_codeword(random_word());
      send_request(OP_DECODE, '0);
      send_request(OP_DECODE, '1);
      send_request(OP_DECODE, cw);
      send_request(OP_DECODE, hamming_codeword(38'h00_ffff_ffff));
      // single message bit errors, first, last and next to last
      send_request(OP_DECODE, flip_at(cw, 3));
      send_request(OP_DECODE, flip_at(cw, CODE_BITS));
      send_request(OP_DECODE, flip_at(cw, 37));
      // parity bit errors
      send_request(OP_DECODE, flip_at(cw, 1));
      send_request(OP_DECODE, flip_at(cw, 32));
      send_request(OP_DECODE, flip_at(cw, 16));
      // syndrome beyond the code length
      send_request(OP_DECODE, flip_at(flip_at(cw, CODE_BITS), 1));
      send_request(OP_DECODE, flip_at(flip_at(cw, 32), 31));
      // double error looks like a message bit error
      send_request(OP_DECODE, flip_at(flip_at(cw, 3), 5));
      send_request(OP_DECODE, 38'h00_0000_0001 << (CODE_BITS - 1));
      wait_for_drain();
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int count);
      logic [DATA_W-1:0] cw;
      int                sel;
      int                p1;
      int                p2;
      send_idle_pct  = sender_pct;
      recv_stall_pct = receiver_pct;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            wait_for_drain();
         end
         sel = $urandom_range(0, 99);
         cw  = hamming_codeword(random_word());
         p1  = $urandom_range(1, CODE_BITS);
         p2  = $urandom_range(1, CODE_BITS);
         if (sel < 30) begin
            send_request(OP_ENCODE, random_word());
         end else if (sel < 70) begin
            send_request(OP_DECODE, flip_at(cw, p1));
         end else if (sel < 80) begin
            send_request(OP_DECODE, cw);
         end else if (sel < 90) begin
            send_request(OP_DECODE, flip_at(flip_at(cw, p1), p2));
         end else begin
            send_request(OP_DECODE, random_word());
         end
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_encode_extremes();
      test_decode_cases();
      test_random_traffic(19, 57, 210);
      test_random_traffic(57, 19, 210);
      test_random_traffic(0, 0, 210);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("hamming_sec_codec verification clean");
      end else begin
         $display("hamming_sec_codec verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("hamming_sec_codec verification failed");
      $finish;
   end

endmodule
